>>> sv/ljpf_pkg.sv
// Shared types, constants and helper functions for the Lennard-Jones pair force block.
// Used by every module of the block; depends on nothing else.
package ljpf_pkg;

    // Number formats.
    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int RES_WIDTH     = 32;
    localparam int VAL_WIDTH     = 64;
    localparam int HALF_WIDTH    = VAL_WIDTH / 2;
    localparam int PROD_WIDTH    = 2 * VAL_WIDTH;
    localparam int DIFF_WIDTH    = COORD_WIDTH + 2;
    localparam int MAG_WIDTH     = COORD_WIDTH + 1;
    localparam int SQ_WIDTH      = 2 * MAG_WIDTH;
    localparam int CFG_IDX_WIDTH = 8;
    localparam int STAT_WIDTH    = 2;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // Latencies of the shared arithmetic units.
    localparam int DIV_STEPS = VAL_WIDTH;
    localparam int MUL_LAT   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIGMA_SQ = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EPSILON  = CFG_IDX_WIDTH'(1);

    // Reset value of both constants: 1.0.
    localparam logic [RES_WIDTH-1:0] ONE_Q = RES_WIDTH'(64'(1) << FRAC_BITS);

    // Status codes.
    localparam logic [STAT_WIDTH-1:0] ST_OK   = STAT_WIDTH'(0);
    localparam logic [STAT_WIDTH-1:0] ST_SAT  = STAT_WIDTH'(1);
    localparam logic [STAT_WIDTH-1:0] ST_ZERO = STAT_WIDTH'(2);

    // Input word: one atom pair.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] first_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
        logic signed [COORD_WIDTH-1:0] shift_x;
        logic signed [COORD_WIDTH-1:0] shift_y;
        logic signed [COORD_WIDTH-1:0] shift_z;
    } t_in_item;

    // Output word: force, energy and virial terms.
    typedef struct packed {
        logic signed [RES_WIDTH-1:0] force_x;
        logic signed [RES_WIDTH-1:0] force_y;
        logic signed [RES_WIDTH-1:0] force_z;
        logic signed [RES_WIDTH-1:0] half_potential;
        logic signed [RES_WIDTH-1:0] half_pressure;
        logic [STAT_WIDTH-1:0]       status;
    } t_out_item;

    // Classified pair as it travels from the front to the back.
    typedef struct packed {
        logic [2:0][MAG_WIDTH-1:0] mag;
        logic [2:0]                neg;
        logic [VAL_WIDTH-1:0]      r2;
        logic                      zero;
        logic                      clamp;
    } t_pair;

    // Queue status seen by both sides.
    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            not_empty;
    } t_q_stat;

    // Product narrowed back to a 64-bit magnitude.
    typedef struct packed {
        logic                 clamp;
        logic [VAL_WIDTH-1:0] val;
    } t_nar;

    // Saturated signed result.
    typedef struct packed {
        logic                        clamp;
        logic signed [RES_WIDTH-1:0] val;
    } t_sat;

    // Drop the fraction bits of a double-width product and clamp to 64 bits.
    function automatic t_nar narrow(input logic [PROD_WIDTH-1:0] p);
        t_nar r;
        r.clamp = |p[PROD_WIDTH-1:VAL_WIDTH+FRAC_BITS];
        r.val   = r.clamp ? {VAL_WIDTH{1'b1}} : p[VAL_WIDTH+FRAC_BITS-1:FRAC_BITS];
        return r;
    endfunction

endpackage

>>> sv/lennard_jones_pair_force_top.sv
// Lennard-Jones 12-6 pair force, top level. One pair is accepted per cycle while o_stall
// is low. Each pair passes through the two 64-step pipelined dividers and the chain of five
// multipliers behind them. Reset is synchronous, active low: it empties the queue and
// pipelines and sets both constants to 1.0; no clearing pass follows.
// Depends on ljpf_pkg, ljpf_front, ljpf_fifo and ljpf_back.
module lennard_jones_pair_force_top
    import ljpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_item                o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [RES_WIDTH-1:0]     i_cfg_data
);

    logic [RES_WIDTH-1:0] r_sigma_sq, r_epsilon;
    logic                 w_push, w_pop;
    t_pair                w_push_pair, w_head;
    t_q_stat              w_q_stat;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_sq <= ONE_Q;
            r_epsilon  <= ONE_Q;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SIGMA_SQ: r_sigma_sq <= i_cfg_data;
                CFG_EPSILON:  r_epsilon  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ljpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_pair   (w_push_pair)
    );

    ljpf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pair   (w_push_pair),
        .i_pop    (w_pop),
        .o_pair   (w_head),
        .o_q_stat (w_q_stat)
    );

    ljpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_pair     (w_head),
        .o_pop      (w_pop),
        .i_sigma_sq (r_sigma_sq),
        .i_epsilon  (r_epsilon),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

>>> sv/ljpf_front.sv
// Front of the pair force block: takes pair words, forms the distance vector and r2.
// Depends on ljpf_pkg; feeds ljpf_fifo.
module ljpf_front
    import ljpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_pair    o_pair
);

    logic                         r_v1, r_v2, r_v3;
    logic signed [DIFF_WIDTH-1:0] r_d1  [3];
    logic [SQ_WIDTH-1:0]          r_sq2 [3];
    logic [2:0][MAG_WIDTH-1:0]    r_mag2;
    logic [2:0]                   r_neg2;
    t_pair                        r_pair3;

    logic                         w_accept;
    logic [Q_CW:0]                w_occ;
    logic signed [DIFF_WIDTH-1:0] n_d1  [3];
    logic signed [DIFF_WIDTH-1:0] w_abs [3];
    logic [SQ_WIDTH-1:0]          n_sq2 [3];
    logic [2:0][MAG_WIDTH-1:0]    n_mag2;
    logic [2:0]                   n_neg2;
    logic [PROD_WIDTH-1:0]        w_sum;
    t_nar                         w_nar;
    t_pair                        n_pair3;

    // Stall when the queue could not hold every word already in flight plus one more.
    assign w_occ    = (Q_CW+1)'(i_q_stat.count) + (Q_CW+1)'(r_v1) + (Q_CW+1)'(r_v2)
                    + (Q_CW+1)'(r_v3);
    assign o_stall  = w_occ >= (Q_CW+1)'(Q_DEPTH);
    assign w_accept = i_valid && !o_stall;

    // Distance vector from the first atom to the second atom's image.
    always_comb begin
        n_d1[0] = DIFF_WIDTH'(i_item.second_x) + DIFF_WIDTH'(i_item.shift_x)
                - DIFF_WIDTH'(i_item.first_x);
        n_d1[1] = DIFF_WIDTH'(i_item.second_y) + DIFF_WIDTH'(i_item.shift_y)
                - DIFF_WIDTH'(i_item.first_y);
        n_d1[2] = DIFF_WIDTH'(i_item.second_z) + DIFF_WIDTH'(i_item.shift_z)
                - DIFF_WIDTH'(i_item.first_z);
    end

    // Split into sign and magnitude, and square each magnitude.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg2[i] = r_d1[i][DIFF_WIDTH-1];
            w_abs[i]  = n_neg2[i] ? -r_d1[i] : r_d1[i];
            n_mag2[i] = w_abs[i][MAG_WIDTH-1:0];
            n_sq2[i]  = SQ_WIDTH'(n_mag2[i]) * SQ_WIDTH'(n_mag2[i]);
        end
    end

    // Sum of squares, back to the fixed point scale, and the zero distance check.
    always_comb begin
        w_sum         = PROD_WIDTH'(r_sq2[0]) + PROD_WIDTH'(r_sq2[1]) + PROD_WIDTH'(r_sq2[2]);
        w_nar         = narrow(w_sum);
        n_pair3.mag   = r_mag2;
        n_pair3.neg   = r_neg2;
        n_pair3.r2    = w_nar.val;
        n_pair3.clamp = w_nar.clamp;
        n_pair3.zero  = (w_nar.val == '0);
    end

    // Valid bits of the three front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge i_clk) begin
        r_d1    <= n_d1;
        r_sq2   <= n_sq2;
        r_mag2  <= n_mag2;
        r_neg2  <= n_neg2;
        r_pair3 <= n_pair3;
    end

    assign o_push = r_v3;
    assign o_pair = r_pair3;

endmodule

>>> sv/ljpf_fifo.sv
// Short word queue that decouples the front from the back of the pair force block.
// Depends on ljpf_pkg.
module ljpf_fifo
    import ljpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pair   i_pair,
    input  logic    i_pop,
    output t_pair   o_pair,
    output t_q_stat o_q_stat
);

    t_pair           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pair;
        end
    end

    assign o_pair             = r_mem[r_rp];
    assign o_q_stat.count     = r_count;
    assign o_q_stat.not_empty = (r_count != '0);

endmodule

>>> sv/ljpf_div.sv
// Pipelined restoring divider: a 128-bit dividend over a 64-bit divisor, one bit a stage.
// Depends on ljpf_pkg; used twice by ljpf_back.
module ljpf_div
    import ljpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [VAL_WIDTH-1:0] i_hi,
    input  logic [VAL_WIDTH-1:0] i_lo,
    input  logic [VAL_WIDTH-1:0] i_dv,
    output logic [VAL_WIDTH-1:0] o_quo,
    output logic                 o_clamp
);

    logic [VAL_WIDTH-1:0] r_rem [DIV_STEPS];
    logic [VAL_WIDTH-1:0] r_quo [DIV_STEPS];
    logic [VAL_WIDTH-1:0] r_lo  [DIV_STEPS];
    logic [VAL_WIDTH-1:0] r_dv  [DIV_STEPS];
    logic                 r_clamp [DIV_STEPS];

    logic [VAL_WIDTH-1:0] n_rem [DIV_STEPS];
    logic [VAL_WIDTH-1:0] n_quo [DIV_STEPS];
    logic [VAL_WIDTH-1:0] n_lo  [DIV_STEPS];
    logic [VAL_WIDTH-1:0] n_dv  [DIV_STEPS];
    logic                 n_clamp [DIV_STEPS];

    // One quotient bit per stage; the quotient clamps when the high half is not below the divisor.
    always_comb begin
        logic [VAL_WIDTH-1:0] p_rem, p_quo, p_lo, p_dv, w_sh;
        logic                 p_clamp, w_take;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                p_rem   = i_hi;
                p_quo   = '0;
                p_lo    = i_lo;
                p_dv    = i_dv;
                p_clamp = (i_hi >= i_dv);
            end else begin
                p_rem   = r_rem[k-1];
                p_quo   = r_quo[k-1];
                p_lo    = r_lo[k-1];
                p_dv    = r_dv[k-1];
                p_clamp = r_clamp[k-1];
            end
            w_sh       = {p_rem[VAL_WIDTH-2:0], p_lo[VAL_WIDTH-1]};
            w_take     = p_rem[VAL_WIDTH-1] || (w_sh >= p_dv);
            n_rem[k]   = w_take ? (w_sh - p_dv) : w_sh;
            n_quo[k]   = {p_quo[VAL_WIDTH-2:0], w_take};
            n_lo[k]    = {p_lo[VAL_WIDTH-2:0], 1'b0};
            n_dv[k]    = p_dv;
            n_clamp[k] = p_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_lo    <= n_lo;
            r_dv    <= n_dv;
            r_clamp <= n_clamp;
        end
    end

    assign o_clamp = r_clamp[DIV_STEPS-1];
    assign o_quo   = r_clamp[DIV_STEPS-1] ? {VAL_WIDTH{1'b1}} : r_quo[DIV_STEPS-1];

endmodule

>>> sv/ljpf_mul.sv
// Two-stage 64 by 64 fixed point multiplier built from four 32 by 32 partial products.
// Depends on ljpf_pkg; used by ljpf_back.
module ljpf_mul
    import ljpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [VAL_WIDTH-1:0] i_a,
    input  logic [VAL_WIDTH-1:0] i_b,
    output logic [VAL_WIDTH-1:0] o_p,
    output logic                 o_clamp
);

    logic [VAL_WIDTH-1:0]  r_p00, r_p01, r_p10, r_p11;
    logic [VAL_WIDTH-1:0]  r_p;
    logic                  r_clamp;
    logic [PROD_WIDTH-1:0] w_sum;
    t_nar                  w_nar;

    // Partial products are summed and narrowed in the second stage.
    always_comb begin
        w_sum = PROD_WIDTH'(r_p00) + (PROD_WIDTH'(r_p01) << HALF_WIDTH)
              + (PROD_WIDTH'(r_p10) << HALF_WIDTH) + (PROD_WIDTH'(r_p11) << VAL_WIDTH);
        w_nar = narrow(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= VAL_WIDTH'(i_a[HALF_WIDTH-1:0]) * VAL_WIDTH'(i_b[HALF_WIDTH-1:0]);
            r_p01   <= VAL_WIDTH'(i_a[HALF_WIDTH-1:0]) * VAL_WIDTH'(i_b[VAL_WIDTH-1:HALF_WIDTH]);
            r_p10   <= VAL_WIDTH'(i_a[VAL_WIDTH-1:HALF_WIDTH]) * VAL_WIDTH'(i_b[HALF_WIDTH-1:0]);
            r_p11   <= VAL_WIDTH'(i_a[VAL_WIDTH-1:HALF_WIDTH])
                     * VAL_WIDTH'(i_b[VAL_WIDTH-1:HALF_WIDTH]);
            r_p     <= w_nar.val;
            r_clamp <= w_nar.clamp;
        end
    end

    assign o_p     = r_p;
    assign o_clamp = r_clamp;

endmodule

>>> sv/ljpf_back.sv
// Back of the pair force block: divisions, power chain, force, energy and virial terms.
// Depends on ljpf_pkg, ljpf_div and ljpf_mul; reads words from ljpf_fifo.
module ljpf_back
    import ljpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_stat              i_q_stat,
    input  t_pair                i_pair,
    output logic                 o_pop,
    input  logic [RES_WIDTH-1:0] i_sigma_sq,
    input  logic [RES_WIDTH-1:0] i_epsilon,
    input  logic                 i_stall,
    output logic                 o_valid,
    output t_out_item            o_result
);

    // Pipeline positions, counted in side line stages after the pop.
    localparam int DIV_OUT  = DIV_STEPS - 1;
    localparam int M1_OUT   = DIV_OUT + MUL_LAT;
    localparam int M2_OUT   = M1_OUT + MUL_LAT;
    localparam int M3_OUT   = M2_OUT + MUL_LAT;
    localparam int STEP     = M3_OUT + 1;
    localparam int M4_OUT   = STEP + MUL_LAT;
    localparam int M6_OUT   = M4_OUT + MUL_LAT;
    localparam int SIDE_LEN = M6_OUT + 1;
    localparam int S_DLY    = M1_OUT - DIV_OUT;
    localparam int INV_DLY  = STEP - DIV_OUT;
    localparam int S3_DLY   = M3_OUT - M2_OUT;
    localparam int SGN_DLY  = M6_OUT - STEP;
    localparam int PM_DLY   = M6_OUT - M4_OUT;

    localparam logic [VAL_WIDTH-1:0] POS_MAX = (VAL_WIDTH'(1) << (RES_WIDTH-1)) - VAL_WIDTH'(1);
    localparam logic [VAL_WIDTH-1:0] NEG_MAX = VAL_WIDTH'(1) << (RES_WIDTH-1);

    logic                 w_en;
    logic [SIDE_LEN-1:0]  r_vld;
    t_pair                r_side [SIDE_LEN];
    t_pair                n_side [SIDE_LEN];
    logic [SIDE_LEN-1:0]  w_add;

    logic [VAL_WIDTH-1:0] r_s_d   [S_DLY];
    logic [VAL_WIDTH-1:0] r_inv_d [INV_DLY];
    logic [VAL_WIDTH-1:0] r_s3_d  [S3_DLY];
    logic [1:0]           r_sgn_d [SGN_DLY];
    logic [VAL_WIDTH-1:0] r_pm_d  [PM_DLY];
    logic [VAL_WIDTH-1:0] r_kdiff, r_pdiff;
    logic                 r_kneg, r_pneg;
    logic                 r_out_valid;
    t_out_item            r_result;

    logic [VAL_WIDTH-1:0] w_e24, w_e4, w_twice, n_kdiff, n_pdiff;
    logic                 n_kneg, n_pneg;
    logic [VAL_WIDTH-1:0] w_s, w_inv, w_sq, w_s3, w_s6, w_kmag, w_pmag, w_vir;
    logic                 w_s_c, w_inv_c, w_sq_c, w_s3_c, w_s6_c, w_km_c, w_pm_c, w_vir_c;
    logic [VAL_WIDTH-1:0] w_fm   [3];
    logic                 w_fm_c [3];
    t_sat                 w_f    [3];
    t_sat                 w_pot, w_pres;
    t_pair                w_last;
    logic                 w_any;
    t_out_item            n_result;

    // Signed saturation of a magnitude to the result width.
    function automatic t_sat sat(input logic neg, input logic [VAL_WIDTH-1:0] mag);
        t_sat                 r;
        logic [VAL_WIDTH-1:0] m;
        if (!neg) begin
            r.clamp = mag > POS_MAX;
            m       = r.clamp ? POS_MAX : mag;
            r.val   = m[RES_WIDTH-1:0];
        end else begin
            r.clamp = mag > NEG_MAX;
            m       = r.clamp ? NEG_MAX : mag;
            m       = -m;
            r.val   = m[RES_WIDTH-1:0];
        end
        return r;
    endfunction

    // The whole back pipeline moves unless a finished word waits on a stalled output.
    assign w_en  = !(r_out_valid && i_stall);
    assign o_pop = w_en && i_q_stat.not_empty;

    // Scaled energy constants.
    assign w_e24 = (VAL_WIDTH'(i_epsilon) << 4) + (VAL_WIDTH'(i_epsilon) << 3);
    assign w_e4  = VAL_WIDTH'(i_epsilon) << 2;

    // s = sigma^2 / r2 and inv = 24 eps / r2.
    ljpf_div u_div_s (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_hi    ('0),
        .i_lo    (VAL_WIDTH'(i_sigma_sq) << FRAC_BITS),
        .i_dv    (i_pair.r2),
        .o_quo   (w_s),
        .o_clamp (w_s_c)
    );

    ljpf_div u_div_inv (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_hi    (w_e24 >> (VAL_WIDTH - FRAC_BITS)),
        .i_lo    (w_e24 << FRAC_BITS),
        .i_dv    (i_pair.r2),
        .o_quo   (w_inv),
        .o_clamp (w_inv_c)
    );

    // Power chain: s^2, s^3, s^6.
    ljpf_mul u_mul_sq (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_s), .i_b(w_s), .o_p(w_sq), .o_clamp(w_sq_c)
    );

    ljpf_mul u_mul_s3 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_sq), .i_b(r_s_d[S_DLY-1]), .o_p(w_s3),
        .o_clamp(w_s3_c)
    );

    ljpf_mul u_mul_s6 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_s3), .i_b(w_s3), .o_p(w_s6), .o_clamp(w_s6_c)
    );

    // Signed differences 2 s^6 - s^3 and s^6 - s^3.
    always_comb begin
        w_twice = w_s6[VAL_WIDTH-1] ? {VAL_WIDTH{1'b1}} : {w_s6[VAL_WIDTH-2:0], 1'b0};
        n_kneg  = w_twice < r_s3_d[S3_DLY-1];
        n_kdiff = n_kneg ? (r_s3_d[S3_DLY-1] - w_twice) : (w_twice - r_s3_d[S3_DLY-1]);
        n_pneg  = w_s6 < r_s3_d[S3_DLY-1];
        n_pdiff = n_pneg ? (r_s3_d[S3_DLY-1] - w_s6) : (w_s6 - r_s3_d[S3_DLY-1]);
    end

    // Force factor magnitude and the energy term.
    ljpf_mul u_mul_k (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_inv_d[INV_DLY-1]), .i_b(r_kdiff), .o_p(w_kmag),
        .o_clamp(w_km_c)
    );

    ljpf_mul u_mul_pot (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_e4), .i_b(r_pdiff), .o_p(w_pmag), .o_clamp(w_pm_c)
    );

    // Force components and the virial term.
    for (genvar g = 0; g < 3; g++) begin : g_force
        ljpf_mul u_mul_f (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_a     (VAL_WIDTH'(r_side[M4_OUT].mag[g])),
            .i_b     (w_kmag),
            .o_p     (w_fm[g]),
            .o_clamp (w_fm_c[g])
        );
    end

    ljpf_mul u_mul_vir (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_kmag), .i_b(r_side[M4_OUT].r2), .o_p(w_vir),
        .o_clamp(w_vir_c)
    );

    // Clamp events folded into the side line as each word passes the unit that saw them.
    always_comb begin
        w_add         = '0;
        w_add[DIV_OUT] = w_s_c | w_inv_c;
        w_add[M1_OUT] = w_sq_c;
        w_add[M2_OUT] = w_s3_c;
        w_add[M3_OUT] = w_s6_c | w_s6[VAL_WIDTH-1];
        w_add[M4_OUT] = w_km_c | w_pm_c;
        n_side[0]     = i_pair;
        for (int k = 1; k < SIDE_LEN; k++) begin
            n_side[k]       = r_side[k-1];
            n_side[k].clamp = r_side[k-1].clamp | w_add[k-1];
        end
    end

    // Saturation and status of the finished word.
    always_comb begin
        w_last = r_side[M6_OUT];
        for (int i = 0; i < 3; i++) begin
            w_f[i] = sat(w_last.neg[i] == r_sgn_d[SGN_DLY-1][1], w_fm[i]);
        end
        w_pot  = sat(r_sgn_d[SGN_DLY-1][0], r_pm_d[PM_DLY-1] >> 1);
        w_pres = sat(r_sgn_d[SGN_DLY-1][1], w_vir >> 1);
        w_any  = w_last.clamp | w_fm_c[0] | w_fm_c[1] | w_fm_c[2] | w_vir_c
               | w_f[0].clamp | w_f[1].clamp | w_f[2].clamp | w_pot.clamp | w_pres.clamp;
        if (w_last.zero) begin
            n_result        = '0;
            n_result.status = ST_ZERO;
        end else begin
            n_result.force_x        = w_f[0].val;
            n_result.force_y        = w_f[1].val;
            n_result.force_z        = w_f[2].val;
            n_result.half_potential = w_pot.val;
            n_result.half_pressure  = w_pres.val;
            n_result.status         = w_any ? ST_SAT : ST_OK;
        end
    end

    // Valid bits of the side line and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[SIDE_LEN-2:0], o_pop};
            r_out_valid <= r_vld[M6_OUT];
        end
    end

    // Payload of the side line, the short delays and the output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side     <= n_side;
            r_s_d[0]   <= w_s;
            r_inv_d[0] <= w_inv;
            r_s3_d[0]  <= w_s3;
            r_sgn_d[0] <= {r_kneg, r_pneg};
            r_pm_d[0]  <= w_pmag;
            for (int k = 1; k < S_DLY; k++) begin
                r_s_d[k] <= r_s_d[k-1];
            end
            for (int k = 1; k < INV_DLY; k++) begin
                r_inv_d[k] <= r_inv_d[k-1];
            end
            for (int k = 1; k < S3_DLY; k++) begin
                r_s3_d[k] <= r_s3_d[k-1];
            end
            for (int k = 1; k < SGN_DLY; k++) begin
                r_sgn_d[k] <= r_sgn_d[k-1];
            end
            for (int k = 1; k < PM_DLY; k++) begin
                r_pm_d[k] <= r_pm_d[k-1];
            end
            r_kdiff  <= n_kdiff;
            r_pdiff  <= n_pdiff;
            r_kneg   <= n_kneg;
            r_pneg   <= n_pneg;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

>>> bench/tb.sv
// Self-checking bench for the Lennard-Jones pair force block: directed and random pairs,
// several constant settings, random idling on both channels. Depends on ljpf_pkg and the top.
`timescale 1ns / 100ps

module tb;
    import ljpf_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    t_in_item                 i_item;
    logic                     o_valid;
    logic                     i_stall;
    t_out_item                o_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index;
    logic [RES_WIDTH-1:0]     i_cfg_data;

    // Local copy of the two constants.
    logic [63:0] sigma_sq_q;
    logic [63:0] eps_q;
    logic        sat_flag;

    t_out_item   force_queue[$];
    int          fail_count;
    int          pairs_sent;
    int          results_seen;
    int          sat_seen;
    int          zero_seen;
    bit          busy_sides;

    lennard_jones_pair_force_top DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("timeout");
        $display("tb NOT OK");
        $finish;
    end

    // Fixed-point helpers.
    function automatic logic [63:0] narrow_prod(input logic [127:0] p);
        if (p[127:80] != 0) begin
            sat_flag = 1'b1;
            return '1;
        end
        return p[79:16];
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        return narrow_prod(128'(a) * 128'(b));
    endfunction

    function automatic logic [63:0] fx_div(input logic [127:0] num, input logic [63:0] dv);
        if (num[127:64] >= dv) begin
            sat_flag = 1'b1;
            return '1;
        end
        return 64'(num / 128'(dv));
    endfunction

    function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag);
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                sat_flag = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 64'h8000_0000) begin
            sat_flag = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(-mag);
    endfunction

    // Predicts the result word of one pair.
    function automatic t_out_item predict_pair_force(input t_in_item it);
        t_out_item   res;
        logic signed [34:0] dv;
        logic [63:0] dmag[3];
        logic        dneg[3];
        logic [127:0] sumsq;
        logic [63:0] r2, s, s3, s6, twice, kdiff, inv, kmag, pdiff, pmag, vmag;
        logic [63:0] e24;
        logic        kneg, pneg;
        logic signed [31:0] a[3], b[3], c[3];
        a[0] = it.first_x;  a[1] = it.first_y;  a[2] = it.first_z;
        b[0] = it.second_x; b[1] = it.second_y; b[2] = it.second_z;
        c[0] = it.shift_x;  c[1] = it.shift_y;  c[2] = it.shift_z;
        sat_flag = 1'b0;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            dv = 35'(b[i]) + 35'(c[i]) - 35'(a[i]);
            dneg[i] = dv < 0;
            dmag[i] = dneg[i] ? 64'(-dv) : 64'(dv);
            sumsq += 128'(dmag[i]) * 128'(dmag[i]);
        end
        r2 = narrow_prod(sumsq);
        res = '0;
        if (r2 == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        s  = fx_div(128'(sigma_sq_q) << 16, r2);
        s3 = fx_mul(fx_mul(s, s), s);
        s6 = fx_mul(s3, s3);
        if (s6[63]) begin
            sat_flag = 1'b1;
            twice = '1;
        end else begin
            twice = s6 << 1;
        end
        kneg  = twice < s3;
        kdiff = kneg ? s3 - twice : twice - s3;
        e24   = eps_q * 24;
        inv   = fx_div(128'(e24) << 16, r2);
        kmag  = fx_mul(inv, kdiff);
        res.force_x = saturate(dneg[0] == kneg, fx_mul(dmag[0], kmag));
        res.force_y = saturate(dneg[1] == kneg, fx_mul(dmag[1], kmag));
        res.force_z = saturate(dneg[2] == kneg, fx_mul(dmag[2], kmag));
        pneg  = s6 < s3;
        pdiff = pneg ? s3 - s6 : s6 - s3;
        pmag  = fx_mul(eps_q * 4, pdiff) >> 1;
        res.half_potential = saturate(pneg, pmag);
        vmag = fx_mul(kmag, r2) >> 1;
        res.half_pressure = saturate(kneg, vmag);
        res.status = sat_flag ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    // Random idle decision: about 31 in 100, none during the busy stretch.
    function automatic bit idle_now();
        return !busy_sides && ($urandom_range(99) < 31);
    endfunction

    // Output side: random stall and checking of each accepted word.
    initial begin
        t_out_item exp_word;
        i_stall = 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                results_seen++;
                if (force_queue.size() == 0) begin
                    $display("result word with nothing expected");
                    fail_count++;
                end else begin
                    exp_word = force_queue.pop_front();
                    if (exp_word.status == ST_SAT) sat_seen++;
                    if (exp_word.status == ST_ZERO) zero_seen++;
                    if (o_result.force_x !== exp_word.force_x)
                        report_mismatch("force_x", o_result.force_x, exp_word.force_x);
                    if (o_result.force_y !== exp_word.force_y)
                        report_mismatch("force_y", o_result.force_y, exp_word.force_y);
                    if (o_result.force_z !== exp_word.force_z)
                        report_mismatch("force_z", o_result.force_z, exp_word.force_z);
                    if (o_result.half_potential !== exp_word.half_potential)
                        report_mismatch("half_potential", o_result.half_potential,
                                        exp_word.half_potential);
                    if (o_result.half_pressure !== exp_word.half_pressure)
                        report_mismatch("half_pressure", o_result.half_pressure,
                                        exp_word.half_pressure);
                    if (o_result.status !== exp_word.status)
                        report_mismatch("status", 32'(o_result.status), 32'(exp_word.status));
                end
            end
            @(negedge i_clk);
            i_stall <= idle_now();
        end
    end

    // Sends one pair word, with a random gap in front of it; valid stays high for the
    // next word, and drain_results drops it.
    task automatic send_pair(input t_in_item it);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        force_queue.push_back(predict_pair_force(it));
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Writes one constant while the block is idle.
    task automatic write_const(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SIGMA_SQ) sigma_sq_q = 64'(val);
        else if (idx == CFG_EPSILON) eps_q = 64'(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (force_queue.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic t_in_item pair_at(input logic signed [31:0] dx,
                                         input logic signed [31:0] dy,
                                         input logic signed [31:0] dz);
        t_in_item it;
        it = '0;
        it.second_x = dx;
        it.second_y = dy;
        it.second_z = dz;
        return it;
    endfunction

    // Random pair; mostly near the interesting range of distances.
    function automatic t_in_item random_pair();
        t_in_item it;
        int sh;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            sh = $urandom_range(31, 12);
            it.second_x = it.first_x + ($signed($urandom) >>> sh) - it.shift_x;
            it.second_y = it.first_y + ($signed($urandom) >>> sh) - it.shift_y;
            it.second_z = it.first_z + ($signed($urandom) >>> sh) - it.shift_z;
        end
        return it;
    endfunction

    task automatic test_directed();
        send_pair(pair_at(32'h0001_0000, 0, 0));
        send_pair(pair_at(-32'sh0001_0000, 0, 0));
        send_pair(pair_at(0, 32'h0001_1F00, 0));
        send_pair(pair_at(0, 0, 32'h0000_8000));
        send_pair(pair_at(32'h0003_0000, 32'h0002_0000, -32'sh0001_0000));
        send_pair(pair_at(0, 0, 0));                      // zero distance
        send_pair(pair_at(32'h0000_0001, 0, 0));          // below resolution
        send_pair(pair_at(32'h0000_0010, 32'h0000_0010, 0));
        send_pair(pair_at(32'h0000_4000, 0, 0));          // very close: saturates
        send_pair(pair_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pair(pair_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        begin
            t_in_item it;
            it = '1;
            send_pair(it);                                // extremes all ones
            it = {9{32'h8000_0000}};
            it.first_x = 32'h7FFF_FFFF;
            send_pair(it);                                // widest difference
            it = {9{32'h7FFF_FFFF}};
            it.first_y = 32'h8000_0000;
            send_pair(it);
        end
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            busy_sides = (n >= count / 3) && (n < count / 3 + 40);
            send_pair(random_pair());
        end
        busy_sides = 1'b0;
        drain_results();
    endtask

    task automatic test_constants();
        write_const(CFG_SIGMA_SQ, 32'h0004_0000);
        write_const(CFG_EPSILON, 32'h0000_4000);
        test_random(100);
        write_const(CFG_SIGMA_SQ, 32'hFFFF_FFFF);
        write_const(CFG_EPSILON, 32'hFFFF_FFFF);
        test_random(60);
        write_const(CFG_SIGMA_SQ, 32'h0000_0001);
        write_const(CFG_EPSILON, 32'h0000_0000);
        test_random(60);
        write_const(8'd5, 32'h1234_5678);                 // unused index: ignored
        write_const(CFG_SIGMA_SQ, 32'h0001_0000);
        write_const(CFG_EPSILON, 32'h0001_0000);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sigma_sq_q  = 64'(ONE_Q);
        eps_q       = 64'(ONE_Q);
        fail_count  = 0;
        busy_sides  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(250);
        test_constants();
        test_random(80);
        $display("pairs %0d, results %0d, saturated %0d, zero distance %0d;",
                 pairs_sent, results_seen, sat_seen, zero_seen);
        $display("constants swept through minimum, default and maximum settings.");
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
